FILE: hdl/mma_pkg.sv
// Shared types and constants for the matrix multiply-accumulate block.
// Depends on nothing; every other file in hdl/ imports it.
`timescale 1ns / 1ps

package mma_pkg;

    // Field widths fixed by the interface
    localparam int DIM_W      = 4;   // dimension registers
    localparam int IDX_W      = 3;   // row / column indexes
    localparam int AB_W       = 16;  // A and B elements, Q8.8
    localparam int C_W        = 32;  // C elements, Q16.16
    localparam int PROD_W     = 2 * AB_W;
    localparam int ACC_W      = 36;  // exact sum of 8 products plus a stored C
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam int DEFAULT_MAX_DIM = 8;
    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_LOAD_C = 2'd2,
        CMD_START  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A     = 2'd0,
        CFG_INNER_DIM  = 2'd1,
        CFG_COLS_B     = 2'd2,
        CFG_ACCUM_MODE = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic             load_en;   // write the accepted load word
        cmd_t             load_sel;  // which store it goes to
        logic             issue;     // read one A/B pair
        logic             first;     // first pair of an element, also read C
        logic             emit;      // present the result and write it back
        logic             last;      // result is the final one of the run
        logic             acc_mode;
        logic [IDX_W-1:0] row_idx;
        logic [IDX_W-1:0] col_idx;
        logic [IDX_W-1:0] inner_idx;
    } mma_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pipe_busy;  // products still in flight
        logic out_free;   // output register can take a word this cycle
    } mma_status_t;

endpackage

FILE: hdl/mma_ctrl.sv
// Controller for the matrix multiply-accumulate block: configuration
// registers, element/inner counters and the sequencing state machine. Uses mma_pkg.
`timescale 1ns / 1ps

module mma_ctrl
    import mma_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel handshake
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_cmd,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // datapath link
    output mma_cmd_t              dp_cmd,
    input  mma_status_t           dp_status
);

    localparam logic [DIM_W-1:0] MAX_D = DIM_W'(MAX_DIM);

    state_t state_reg, state_next;

    logic [DIM_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;
    logic             accum_mode_reg;

    logic [IDX_W-1:0] r_reg, r_next;
    logic [IDX_W-1:0] c_reg, c_next;
    logic [IDX_W-1:0] m_reg, m_next;

    logic [DIM_W-1:0] nr, nm, nc;
    logic             dims_zero;
    logic             in_accept;
    logic             start_go;
    logic             last_inner, last_col, last_row;
    logic             emit_now;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        clamp_dim = (d > MAX_D) ? MAX_D : d;
    endfunction

    // Effective dimensions
    assign nr        = clamp_dim(rows_a_reg);
    assign nm        = clamp_dim(inner_dim_reg);
    assign nc        = clamp_dim(cols_b_reg);
    assign dims_zero = (nr == '0) || (nm == '0) || (nc == '0);

    assign in_accept  = s_valid && s_ready;
    assign start_go   = in_accept && (cmd_t'(s_cmd) == CMD_START) && !dims_zero;
    assign last_inner = ({1'b0, m_reg} == nm - 1'b1);
    assign last_col   = ({1'b0, c_reg} == nc - 1'b1);
    assign last_row   = ({1'b0, r_reg} == nr - 1'b1);
    assign emit_now   = (state_reg == ST_DRAIN) && !dp_status.pipe_busy &&
                        dp_status.out_free;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_go) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (last_inner) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (emit_now) begin
                    state_next = (last_row && last_col) ? ST_IDLE : ST_ISSUE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and counter updates
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        cfg_ready = 1'b1;
        r_next    = r_reg;
        c_next    = c_reg;
        m_next    = m_reg;

        dp_cmd           = '0;
        dp_cmd.load_sel  = cmd_t'(s_cmd);
        dp_cmd.acc_mode  = accum_mode_reg;
        dp_cmd.row_idx   = r_reg;
        dp_cmd.col_idx   = c_reg;
        dp_cmd.inner_idx = m_reg;
        dp_cmd.last      = last_row && last_col;

        unique case (state_reg)
            ST_IDLE: begin
                dp_cmd.load_en = in_accept && (cmd_t'(s_cmd) != CMD_START);
                if (start_go) begin
                    r_next = '0;
                    c_next = '0;
                    m_next = '0;
                end
            end
            ST_ISSUE: begin
                dp_cmd.issue = 1'b1;
                dp_cmd.first = (m_reg == '0);
                m_next       = last_inner ? '0 : m_reg + 1'b1;
            end
            ST_DRAIN: begin
                dp_cmd.emit = emit_now;
                if (emit_now) begin
                    if (last_col) begin
                        c_next = '0;
                        r_next = r_reg + 1'b1;
                    end else begin
                        c_next = c_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // State and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            r_reg     <= '0;
            c_reg     <= '0;
            m_reg     <= '0;
        end else begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            m_reg     <= m_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg     <= DIM_RESET;
            inner_dim_reg  <= DIM_RESET;
            cols_b_reg     <= DIM_RESET;
            accum_mode_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ROWS_A:     rows_a_reg     <= cfg_data;
                CFG_INNER_DIM:  inner_dim_reg  <= cfg_data;
                CFG_COLS_B:     cols_b_reg     <= cfg_data;
                CFG_ACCUM_MODE: accum_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

FILE: hdl/mma_datapath.sv
// Datapath of the matrix multiply-accumulate block: A, B and C stores,
// multiply pipeline, accumulator, saturation and the output register. Uses mma_pkg.
`timescale 1ns / 1ps

module mma_datapath
    import mma_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mma_cmd_t                 dp_cmd,
    output mma_status_t              dp_status,
    // load word payload
    input  logic [IDX_W-1:0]         s_row,
    input  logic [IDX_W-1:0]         s_col,
    input  logic signed [AB_W-1:0]   s_ab_value,
    input  logic signed [C_W-1:0]    s_c_value,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [IDX_W-1:0]         m_out_row,
    output logic [IDX_W-1:0]         m_out_col,
    output logic signed [C_W-1:0]    m_out_value,
    output logic                     m_last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [AB_W-1:0] a_mem [DEPTH];
    logic signed [AB_W-1:0] b_mem [DEPTH];
    logic signed [C_W-1:0]  c_mem [DEPTH];

    logic signed [AB_W-1:0]   a_q_reg, b_q_reg;
    logic signed [C_W-1:0]    c_q_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next, acc_base;
    logic                     v1_reg, v2_reg, f1_reg, f2_reg;

    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_row_reg, out_col_reg;
    logic signed [C_W-1:0]    out_value_reg;
    logic                     out_last_reg;

    logic                     load_in_range;
    logic [AW-1:0]            load_addr, a_addr, b_addr, c_addr, c_wr_addr;
    logic                     c_we;
    logic signed [C_W-1:0]    c_wr_data;
    logic signed [C_W-1:0]    sat_value;
    logic                     sat_hi, sat_lo;

    function automatic logic [AW-1:0] flat(input logic [IDX_W-1:0] r,
                                           input logic [IDX_W-1:0] c);
        flat = AW'(int'(r) * MAX_DIM + int'(c));
    endfunction

    // Addresses
    assign load_in_range = (int'(s_row) < MAX_DIM) && (int'(s_col) < MAX_DIM);
    assign load_addr     = flat(s_row, s_col);
    assign a_addr        = flat(dp_cmd.row_idx, dp_cmd.inner_idx);
    assign b_addr        = flat(dp_cmd.inner_idx, dp_cmd.col_idx);
    assign c_addr        = flat(dp_cmd.row_idx, dp_cmd.col_idx);

    // C store write port is shared by loads and result write-back
    assign c_we      = dp_cmd.emit ||
                       (dp_cmd.load_en && load_in_range && dp_cmd.load_sel == CMD_LOAD_C);
    assign c_wr_addr = dp_cmd.emit ? c_addr : load_addr;
    assign c_wr_data = dp_cmd.emit ? sat_value : s_c_value;

    // A store
    always_ff @(posedge aclk) begin
        if (dp_cmd.load_en && load_in_range && dp_cmd.load_sel == CMD_LOAD_A) begin
            a_mem[load_addr] <= s_ab_value;
        end
        if (dp_cmd.issue) begin
            a_q_reg <= a_mem[a_addr];
        end
    end

    // B store
    always_ff @(posedge aclk) begin
        if (dp_cmd.load_en && load_in_range && dp_cmd.load_sel == CMD_LOAD_B) begin
            b_mem[load_addr] <= s_ab_value;
        end
        if (dp_cmd.issue) begin
            b_q_reg <= b_mem[b_addr];
        end
    end

    // C store: read once per element, written on load or write-back
    always_ff @(posedge aclk) begin
        if (c_we) begin
            c_mem[c_wr_addr] <= c_wr_data;
        end
        if (dp_cmd.issue && dp_cmd.first) begin
            c_q_reg <= c_mem[c_addr];
        end
    end

    // Multiply stage
    always_ff @(posedge aclk) begin
        prod_reg <= a_q_reg * b_q_reg;
    end

    // Accumulate: first product starts from stored C or zero
    assign acc_base = dp_cmd.acc_mode ?
                      {{(ACC_W-C_W){c_q_reg[C_W-1]}}, c_q_reg} : '0;
    assign acc_next = (f2_reg ? acc_base : acc_reg) +
                      {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_ff @(posedge aclk) begin
        if (v2_reg) begin
            acc_reg <= acc_next;
        end
    end

    // Pipeline valid and first-pair tags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            f1_reg <= 1'b0;
            f2_reg <= 1'b0;
        end else begin
            v1_reg <= dp_cmd.issue;
            v2_reg <= v1_reg;
            f1_reg <= dp_cmd.issue && dp_cmd.first;
            f2_reg <= f1_reg;
        end
    end

    // Clamp to signed 32 bits
    assign sat_hi    = !acc_reg[ACC_W-1] && (|acc_reg[ACC_W-2:C_W-1]);
    assign sat_lo    = acc_reg[ACC_W-1] && !(&acc_reg[ACC_W-2:C_W-1]);
    assign sat_value = sat_hi ? {1'b0, {(C_W-1){1'b1}}} :
                       sat_lo ? {1'b1, {(C_W-1){1'b0}}} :
                       acc_reg[C_W-1:0];

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (dp_cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.emit) begin
            out_row_reg   <= dp_cmd.row_idx;
            out_col_reg   <= dp_cmd.col_idx;
            out_value_reg <= sat_value;
            out_last_reg  <= dp_cmd.last;
        end
    end

    assign dp_status.pipe_busy = v1_reg || v2_reg;
    assign dp_status.out_free  = !out_valid_reg || m_ready;

    assign m_valid     = out_valid_reg;
    assign m_out_row   = out_row_reg;
    assign m_out_col   = out_col_reg;
    assign m_out_value = out_value_reg;
    assign m_last      = out_last_reg;

endmodule

FILE: hdl/matrix_multiply_accumulate.sv
// Top level of the matrix multiply-accumulate block: joins controller and datapath.
// Depends on mma_pkg, mma_ctrl and mma_datapath.
`timescale 1ns / 1ps

// Computes C = A x B (or C += A x B with accumulate_mode set) on matrices of up to
// MAX_DIM x MAX_DIM. A load word (cmd 0, 1, 2) writes one element of A, B or C and
// is taken while the block is idle; loads outside the array are dropped. A start
// word streams every C element out in row-major order with m_last on the final one
// and writes each result back into the C store. One shared multiplier with a single
// read port per store sets the rate: each element issues inner_dim multiplies, then
// drains the read, multiply and accumulate registers and emits its result before the
// next element starts, so a start holds the input channel until the last result is
// emitted, longer if the result channel stalls. A start with any zero dimension emits
// nothing. Stores power up undefined; read only what was loaded. Configuration is to
// be written by the user only while the block is idle; the block does not enforce it.

module matrix_multiply_accumulate
    import mma_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input words
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_cmd,
    input  logic [IDX_W-1:0]       s_row,
    input  logic [IDX_W-1:0]       s_col,
    input  logic signed [AB_W-1:0] s_ab_value,
    input  logic signed [C_W-1:0]  s_c_value,
    // result words
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [IDX_W-1:0]       m_out_row,
    output logic [IDX_W-1:0]       m_out_col,
    output logic signed [C_W-1:0]  m_out_value,
    output logic                   m_last
);

    mma_cmd_t    dp_cmd;
    mma_status_t dp_status;

    mma_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

    mma_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .dp_cmd      (dp_cmd),
        .dp_status   (dp_status),
        .s_row       (s_row),
        .s_col       (s_col),
        .s_ab_value  (s_ab_value),
        .s_c_value   (s_c_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_out_value (m_out_value),
        .m_last      (m_last)
    );

endmodule

FILE: hdl/mma_checker.sv
// Port-level checker for the matrix multiply-accumulate block, bound to the top level.
// Depends on mma_pkg and matrix_multiply_accumulate.
`timescale 1ns / 1ps

module mma_checker
    import mma_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic [1:0]             s_cmd,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [IDX_W-1:0]       m_out_row,
    input logic [IDX_W-1:0]       m_out_col,
    input logic signed [C_W-1:0]  m_out_value,
    input logic                   m_last
);

    // A stalled result word stays valid
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_out_value) && $stable(m_out_row) &&
                                $stable(m_out_col) && $stable(m_last))
        else $error("result payload changed while stalled");

    // Results only appear while a start is being worked off
    a_emit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result word appeared while idle");

    // A load word never produces a result
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (cmd_t'(s_cmd) != CMD_START) |=> !$rose(m_valid))
        else $error("load word produced a result");

endmodule

bind matrix_multiply_accumulate mma_checker u_mma_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_cmd       (s_cmd),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_row   (m_out_row),
    .m_out_col   (m_out_col),
    .m_out_value (m_out_value),
    .m_last      (m_last)
);

FILE: sim/tb_top.sv
// Self-checking testbench for matrix_multiply_accumulate: loads A, B and C elements,
// starts runs under many dimension settings and checks every emitted C word.
// Depends on mma_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb_top;
    import mma_pkg::*;

    localparam int DIM           = DEFAULT_MAX_DIM;
    localparam int CELLS         = DIM * DIM;
    localparam int RANDOM_WORDS  = 120;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam longint SUM_MAX   = 64'sd2147483647;
    localparam longint SUM_MIN   = -64'sd2147483648;

    typedef struct packed {
        cmd_t                   cmd;
        logic [IDX_W-1:0]       row;
        logic [IDX_W-1:0]       col;
        logic signed [AB_W-1:0] ab;
        logic signed [C_W-1:0]  cv;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]      row;
        logic [IDX_W-1:0]      col;
        logic signed [C_W-1:0] value;
        logic                  last;
    } c_word_t;

    // DUT ports
    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_cmd = '0;
    logic [IDX_W-1:0]       s_row = '0;
    logic [IDX_W-1:0]       s_col = '0;
    logic signed [AB_W-1:0] s_ab_value = '0;
    logic signed [C_W-1:0]  s_c_value = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [IDX_W-1:0]       m_out_row;
    logic [IDX_W-1:0]       m_out_col;
    logic signed [C_W-1:0]  m_out_value;
    logic                   m_last;

    // Stimulus bookkeeping
    bit  a_loaded [CELLS];
    bit  b_loaded [CELLS];
    bit  c_loaded [CELLS];
    bit  idle_on = 1'b1;
    bit  hold_sink = 1'b0;
    int  words_sent = 0;

    matrix_multiply_accumulate dut (.*);

    // Dimension register as the block uses it: anything above MAX_DIM counts as MAX_DIM
    function automatic int fit_dim(logic [DIM_W-1:0] d);
        return (d > DIM) ? DIM : int'(d);
    endfunction

    // Scoreboard: mirrors the stores and registers, queues the C words each start owes
    class gemm_scoreboard;
        logic signed [AB_W-1:0] a_mem [CELLS];
        logic signed [AB_W-1:0] b_mem [CELLS];
        logic signed [C_W-1:0]  c_mem [CELLS];
        logic [DIM_W-1:0]       rows_reg;
        logic [DIM_W-1:0]       inner_reg;
        logic [DIM_W-1:0]       cols_reg;
        logic                   accum_reg;
        c_word_t                c_words_due [$];
        int                     errors;

        function new();
            foreach (a_mem[i]) begin
                a_mem[i] = '0;
                b_mem[i] = '0;
                c_mem[i] = '0;
            end
            rows_reg  = DIM_RESET;
            inner_reg = DIM_RESET;
            cols_reg  = DIM_RESET;
            accum_reg = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ROWS_A:     rows_reg  = data;
                CFG_INNER_DIM:  inner_reg = data;
                CFG_COLS_B:     cols_reg  = data;
                CFG_ACCUM_MODE: accum_reg = data[0];
                default: ;
            endcase
        endfunction

        // Every C element in row-major order, exact sum saturated once, written back
        function void compute_c_run();
            int      nr, nm, nc, r, c, m;
            longint  sum;
            c_word_t res;
            nr = fit_dim(rows_reg);
            nm = fit_dim(inner_reg);
            nc = fit_dim(cols_reg);
            if (nr == 0 || nm == 0 || nc == 0)
                return;
            for (r = 0; r < nr; r++) begin
                for (c = 0; c < nc; c++) begin
                    sum = accum_reg ? longint'(c_mem[r * DIM + c]) : 64'sd0;
                    for (m = 0; m < nm; m++)
                        sum += longint'(a_mem[r * DIM + m]) * longint'(b_mem[m * DIM + c]);
                    if (sum > SUM_MAX)
                        sum = SUM_MAX;
                    else if (sum < SUM_MIN)
                        sum = SUM_MIN;
                    res.row   = IDX_W'(r);
                    res.col   = IDX_W'(c);
                    res.value = sum[C_W-1:0];
                    res.last  = (r == nr - 1) && (c == nc - 1);
                    c_mem[r * DIM + c] = res.value;
                    c_words_due.push_back(res);
                end
            end
        endfunction

        function void accept_word(in_word_t w);
            int slot;
            slot = int'(w.row) * DIM + int'(w.col);
            case (w.cmd)
                CMD_LOAD_A: a_mem[slot] = w.ab;
                CMD_LOAD_B: b_mem[slot] = w.ab;
                CMD_LOAD_C: c_mem[slot] = w.cv;
                CMD_START:  compute_c_run();
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("%0t ERROR %s", $time, msg);
        endtask

        task check_c_word(c_word_t got);
            c_word_t want;
            if (c_words_due.size() == 0) begin
                report_mismatch($sformatf("unexpected C word row %0d col %0d value %0d",
                                          got.row, got.col, got.value));
                return;
            end
            want = c_words_due.pop_front();
            if (got.row !== want.row)
                report_mismatch($sformatf("C[%0d][%0d] out_row: got %0d",
                                          want.row, want.col, got.row));
            if (got.col !== want.col)
                report_mismatch($sformatf("C[%0d][%0d] out_col: got %0d",
                                          want.row, want.col, got.col));
            if (got.value !== want.value)
                report_mismatch($sformatf("C[%0d][%0d] out_value: got %0d, expected %0d",
                                          want.row, want.col, got.value, want.value));
            if (got.last !== want.last)
                report_mismatch($sformatf("C[%0d][%0d] last: got %0b, expected %0b",
                                          want.row, want.col, got.last, want.last));
        endtask
    endclass

    gemm_scoreboard sb;

    // Element values: extremes, values within +-2.0 and full-range noise
    function automatic logic signed [AB_W-1:0] rand_ab();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2, 3:    return AB_W'($urandom_range(0, 1023)) - 16'sd512;
            default: return AB_W'($urandom());
        endcase
    endfunction

    function automatic logic signed [C_W-1:0] rand_c();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3:    return C_W'($urandom_range(0, 1 << 18)) - 32'sd131072;
            default: return C_W'($urandom());
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] rand_dim();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return DIM_W'(DIM);
        if (pick == 2)
            return DIM_W'($urandom_range(DIM + 1, 15));
        return DIM_W'($urandom_range(1, 4));
    endfunction

    // Unused fields carry noise too
    function automatic in_word_t word_of(cmd_t cmd, int row, int col);
        in_word_t w;
        w.cmd = cmd;
        w.row = IDX_W'(row);
        w.col = IDX_W'(col);
        w.ab  = rand_ab();
        w.cv  = rand_c();
        return w;
    endfunction

    function automatic in_word_t any_load();
        return word_of(cmd_t'($urandom_range(0, 2)), $urandom_range(0, DIM - 1),
                       $urandom_range(0, DIM - 1));
    endfunction

    function automatic in_word_t start_word();
        return word_of(CMD_START, $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1));
    endfunction

    // Offer one input word, hold it until taken, then update the scoreboard
    task automatic send_word(in_word_t w);
        int slot, r, c;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_cmd      <= w.cmd;
        s_row      <= w.row;
        s_col      <= w.col;
        s_ab_value <= w.ab;
        s_c_value  <= w.cv;
        do @(posedge aclk); while (!s_ready);
        // C coverage must be read before the scoreboard runs the start
        slot = int'(w.row) * DIM + int'(w.col);
        case (w.cmd)
            CMD_LOAD_A: a_loaded[slot] = 1'b1;
            CMD_LOAD_B: b_loaded[slot] = 1'b1;
            CMD_LOAD_C: c_loaded[slot] = 1'b1;
            CMD_START: begin
                // a run writes back every C element it covers
                if (fit_dim(sb.rows_reg) * fit_dim(sb.inner_reg) * fit_dim(sb.cols_reg) != 0)
                    for (r = 0; r < fit_dim(sb.rows_reg); r++)
                        for (c = 0; c < fit_dim(sb.cols_reg); c++)
                            c_loaded[r * DIM + c] = 1'b1;
            end
            default: ;
        endcase
        sb.accept_word(w);
        words_sent++;
    endtask

    task automatic put(cmd_t cmd, int row, int col, longint value);
        in_word_t w;
        w = word_of(cmd, row, col);
        if (cmd == CMD_LOAD_C)
            w.cv = C_W'(value);
        else
            w.ab = AB_W'(value);
        send_word(w);
    endtask

    // Load every element the next start reads that has not been written yet
    task automatic load_missing();
        int nr, nm, nc, r, c, m;
        nr = fit_dim(sb.rows_reg);
        nm = fit_dim(sb.inner_reg);
        nc = fit_dim(sb.cols_reg);
        if (nr == 0 || nm == 0 || nc == 0)
            return;
        for (r = 0; r < nr; r++)
            for (m = 0; m < nm; m++)
                if (!a_loaded[r * DIM + m])
                    send_word(word_of(CMD_LOAD_A, r, m));
        for (m = 0; m < nm; m++)
            for (c = 0; c < nc; c++)
                if (!b_loaded[m * DIM + c])
                    send_word(word_of(CMD_LOAD_B, m, c));
        if (sb.accum_reg)
            for (r = 0; r < nr; r++)
                for (c = 0; c < nc; c++)
                    if (!c_loaded[r * DIM + c])
                        send_word(word_of(CMD_LOAD_C, r, c));
    endtask

    // Stop offering, let every owed C word arrive, then let the block settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.c_words_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] inner,
                              logic [DIM_W-1:0] cols, logic accum);
        wait_idle();
        cfg_write(CFG_ROWS_A, rows);
        cfg_write(CFG_INNER_DIM, inner);
        cfg_write(CFG_COLS_B, cols);
        cfg_write(CFG_ACCUM_MODE, CFG_DATA_W'(accum));
        cfg_valid <= 1'b0;
    endtask

    // Clock
    initial begin : clock_gen
        forever #5 aclk = ~aclk;
    end

    // Result sink: random stalls, plus one long hold-off on request
    initial begin : c_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_c_word(c_word_t'{m_out_row, m_out_col, m_out_value, m_last});
            if (hold_sink) begin
                hold_sink = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        int starts;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Saturation both ways on a 1 x 2 x 2 product, overwrite then accumulate
        set_config(4'd1, 4'd2, 4'd2, 1'b0);
        put(CMD_LOAD_A, 0, 0, -32768);
        put(CMD_LOAD_A, 0, 1, -32768);
        put(CMD_LOAD_B, 0, 0, -32768);
        put(CMD_LOAD_B, 1, 0, -32768);
        put(CMD_LOAD_B, 0, 1, 32767);
        put(CMD_LOAD_B, 1, 1, 1);
        send_word(start_word());
        set_config(4'd1, 4'd2, 4'd2, 1'b1);
        put(CMD_LOAD_C, 0, 0, SUM_MAX);
        put(CMD_LOAD_C, 0, 1, SUM_MIN);
        send_word(start_word());

        // Any zero dimension: start emits nothing
        set_config(4'd0, 4'd2, 4'd2, 1'b0);
        send_word(start_word());
        set_config(4'd1, 4'd0, 4'd2, 1'b1);
        send_word(start_word());
        set_config(4'd1, 4'd2, 4'd0, 1'b0);
        send_word(start_word());

        // Column count above MAX_DIM runs as MAX_DIM
        set_config(4'd1, 4'd1, 4'd12, 1'b0);
        load_missing();
        send_word(start_word());

        // Widest result run against a long-stalled sink; loads pile up behind it
        set_config(4'd8, 4'd1, 4'd8, 1'b0);
        load_missing();
        hold_sink = 1'b1;
        send_word(start_word());
        repeat (6) send_word(any_load());

        // Deepest inner product, accumulating
        set_config(4'd1, 4'd8, 4'd1, 1'b1);
        load_missing();
        send_word(start_word());

        // Random phases: new settings, some loads, fill what the run reads, start
        while (words_sent < RANDOM_WORDS) begin
            idle_on = (words_sent < RANDOM_WORDS - 30) && ($urandom_range(0, 4) != 0);
            set_config(rand_dim(), rand_dim(), rand_dim(), 1'($urandom_range(0, 1)));
            starts = $urandom_range(1, 3);
            repeat (starts) begin
                repeat ($urandom_range(0, 6)) send_word(any_load());
                load_missing();
                send_word(start_word());
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.c_words_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(20_000_000);
        $display("%0t ERROR timeout with %0d C words outstanding", $time,
                 sb.c_words_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
